// ===== rtl/bpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types and codes for the Bezier point evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

  localparam int CFG_IDX_BITS = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DEGREE      = 3'd0,
    REG_POINT_ZERO  = 3'd1,
    REG_POINT_ONE   = 3'd2,
    REG_POINT_TWO   = 3'd3,
    REG_POINT_THREE = 3'd4
  } bpe_reg_t;

  // load enables for the per-axis stages
  typedef struct packed {
    logic mul;
    logic pair;
    logic total;
  } bpe_adv_t;

endpackage

// ===== rtl/bpe_axis.sv =====
// ----------------------------------------------------------------------------
// bpe_axis
// One coordinate axis: weight times control point, pairwise sum, final sum
// with round to nearest. Three register stages.
// ----------------------------------------------------------------------------
module bpe_axis import bpe_pkg::*; #(
  parameter int WB    = 49,
  parameter int CBITS = 16
) (
  input  logic              clk,
  input  bpe_adv_t          adv,
  input  logic [WB-1:0]     w0,
  input  logic [WB-1:0]     w1,
  input  logic [WB-1:0]     w2,
  input  logic [WB-1:0]     w3,
  input  logic [CBITS-1:0]  c0,
  input  logic [CBITS-1:0]  c1,
  input  logic [CBITS-1:0]  c2,
  input  logic [CBITS-1:0]  c3,
  output logic [CBITS-1:0]  coord
);

  localparam int PW    = WB + CBITS;
  localparam int SHIFT = WB - 1;

  logic [PW-1:0] prod0, prod1, prod2, prod3;
  logic [PW:0]   sum01, sum23;
  logic [PW+1:0] total;
  logic [PW+1:0] half;

  assign half  = (PW+2)'(1) << (SHIFT - 1);
  assign total = {1'b0, sum01} + {1'b0, sum23} + half;

  always_ff @(posedge clk) begin
    if (adv.mul) begin
      prod0 <= PW'(w0 * c0);
      prod1 <= PW'(w1 * c1);
      prod2 <= PW'(w2 * c2);
      prod3 <= PW'(w3 * c3);
    end
    if (adv.pair) begin
      sum01 <= {1'b0, prod0} + {1'b0, prod1};
      sum23 <= {1'b0, prod2} + {1'b0, prod3};
    end
    // drop the fraction; the convex sum keeps the integer part in range
    if (adv.total) begin
      coord <= total[SHIFT +: CBITS];
    end
  end

endmodule

// ===== rtl/bezier_point_eval.sv =====
// ----------------------------------------------------------------------------
// bezier_point_eval
// Bernstein-form Bezier evaluator, degree 0 to 3, one point per word.
// ----------------------------------------------------------------------------
// Usage:
//   Write degree and control points on the cfg port while the block is idle.
//   Each point holds x in the upper COORD_BITS bits and y in the lower bits.
//   Input words carry t_param (Q1.T_FRAC_BITS, values above 1.0 clamp to 1.0)
//   under in_valid / in_stall; results leave as x_coord / y_coord under
//   out_valid / out_stall.
//   A word passes through the stages in order; out_valid rises once it reaches
//   the last stage, the rounded total register. One word enters per cycle
//   while in_stall is low; the seven-stage pipeline (clamp, square, cube, weight
//   select, coordinate multiply, pair sum, rounded total) sets that rate.
//   A stall from the receiver holds the output register; stages behind it
//   keep filling bubbles, and in_stall rises only once every stage is full.
//   Nothing is lost or repeated across a stall.
//   Reset empties the pipeline, sets degree to 3 and clears all points.
//   Degrees above MAX_DEGREE act as MAX_DEGREE; degree 0 returns point zero.
// ----------------------------------------------------------------------------
module bezier_point_eval import bpe_pkg::*; #(
  parameter int COORD_BITS  = 16,
  parameter int T_FRAC_BITS = 16,
  parameter int MAX_DEGREE  = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [2*COORD_BITS-1:0]   cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [T_FRAC_BITS:0]      t_param,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COORD_BITS-1:0]     x_coord,
  output logic [COORD_BITS-1:0]     y_coord
);

  localparam int T      = T_FRAC_BITS;
  localparam int C      = COORD_BITS;
  localparam int PB     = 2 * C;
  localparam int W1     = T + 1;
  localparam int W2     = 2 * T + 1;
  localparam int WB     = 3 * T + 1;
  localparam int STAGES = 7;
  localparam logic [1:0] MAX_N = 2'(MAX_DEGREE);

  logic [W1-1:0] one;
  logic [WB-1:0] one3;
  assign one  = W1'(1) << T;
  assign one3 = WB'(1) << (3 * T);

  // configuration
  logic [1:0]    degree;
  logic [PB-1:0] point [4];
  logic [1:0]    n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= 2'd3;
      for (int i = 0; i < 4; i++) point[i] <= '0;
    end else if (cfg_we) begin
      unique case (bpe_reg_t'(cfg_index))
        REG_DEGREE:      degree   <= cfg_data[1:0];
        REG_POINT_ZERO:  point[0] <= cfg_data;
        REG_POINT_ONE:   point[1] <= cfg_data;
        REG_POINT_TWO:   point[2] <= cfg_data;
        REG_POINT_THREE: point[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n_eff = (degree > MAX_N) ? MAX_N : degree;

  // valid chain and stage enables; a stage loads when empty or moving on
  logic [STAGES:1] vld;
  logic [STAGES:1] en;

  always_comb begin
    en[STAGES] = !vld[STAGES] || !out_stall;
    for (int i = STAGES - 1; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in_valid;
      for (int i = 2; i <= STAGES; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 1: clamp t, form 1 - t
  logic [W1-1:0] s1_t, s1_u;
  logic [W1-1:0] t_clamp;
  assign t_clamp = (t_param > one) ? one : t_param;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_t <= t_clamp;
      s1_u <= one - t_clamp;
    end
  end

  // stage 2: squares and cross product
  logic [W1-1:0]  s2_t, s2_u;
  logic [W2-1:0]  s2_tt, s2_uu, s2_tu;
  logic [2*W1-1:0] m_tt, m_uu, m_tu;
  assign m_tt = s1_t * s1_t;
  assign m_uu = s1_u * s1_u;
  assign m_tu = s1_t * s1_u;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_t  <= s1_t;
      s2_u  <= s1_u;
      s2_tt <= m_tt[W2-1:0];
      s2_uu <= m_uu[W2-1:0];
      s2_tu <= m_tu[W2-1:0];
    end
  end

  // stage 3: cubic terms
  logic [W1-1:0]  s3_t, s3_u;
  logic [W2-1:0]  s3_tt, s3_uu, s3_tu;
  logic [WB-1:0]  s3_uuu, s3_uut, s3_utt, s3_ttt;
  logic [WB:0]    m_uuu, m_uut, m_utt, m_ttt;
  assign m_uuu = s2_uu * s2_u;
  assign m_uut = s2_uu * s2_t;
  assign m_utt = s2_tu * s2_t;
  assign m_ttt = s2_tt * s2_t;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_t   <= s2_t;
      s3_u   <= s2_u;
      s3_tt  <= s2_tt;
      s3_uu  <= s2_uu;
      s3_tu  <= s2_tu;
      s3_uuu <= m_uuu[WB-1:0];
      s3_uut <= m_uut[WB-1:0];
      s3_utt <= m_utt[WB-1:0];
      s3_ttt <= m_ttt[WB-1:0];
    end
  end

  // stage 4: Bernstein weights, all scaled to 2^(3T)
  logic [WB-1:0] w_next [4];
  logic [WB-1:0] w      [4];
  logic [WB+1:0] three_uut, three_utt;
  assign three_uut = ({2'b00, s3_uut} << 1) + {2'b00, s3_uut};
  assign three_utt = ({2'b00, s3_utt} << 1) + {2'b00, s3_utt};

  always_comb begin
    for (int k = 0; k < 4; k++) w_next[k] = '0;
    unique case (n_eff)
      2'd0: begin
        w_next[0] = one3;
      end
      2'd1: begin
        w_next[0] = {s3_u, {(2*T){1'b0}}};
        w_next[1] = {s3_t, {(2*T){1'b0}}};
      end
      2'd2: begin
        w_next[0] = {s3_uu, {T{1'b0}}};
        // 2tu never exceeds half of full scale, so its top bit is clear
        w_next[1] = {s3_tu[W2-2:0], {(T+1){1'b0}}};
        w_next[2] = {s3_tt, {T{1'b0}}};
      end
      2'd3: begin
        w_next[0] = s3_uuu;
        w_next[1] = three_uut[WB-1:0];
        w_next[2] = three_utt[WB-1:0];
        w_next[3] = s3_ttt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 4; k++) w[k] <= w_next[k];
    end
  end

  // stages 5 to 7, one unit per axis
  bpe_adv_t adv;
  assign adv.mul   = en[5];
  assign adv.pair  = en[6];
  assign adv.total = en[7];

  bpe_axis #(
    .WB    (WB),
    .CBITS (C)
  ) u_axis_x (
    .clk   (clk),
    .adv   (adv),
    .w0    (w[0]),
    .w1    (w[1]),
    .w2    (w[2]),
    .w3    (w[3]),
    .c0    (point[0][PB-1:C]),
    .c1    (point[1][PB-1:C]),
    .c2    (point[2][PB-1:C]),
    .c3    (point[3][PB-1:C]),
    .coord (x_coord)
  );

  bpe_axis #(
    .WB    (WB),
    .CBITS (C)
  ) u_axis_y (
    .clk   (clk),
    .adv   (adv),
    .w0    (w[0]),
    .w1    (w[1]),
    .w2    (w[2]),
    .w3    (w[3]),
    .c0    (point[0][C-1:0]),
    .c1    (point[1][C-1:0]),
    .c2    (point[2][C-1:0]),
    .c3    (point[3][C-1:0]),
    .coord (y_coord)
  );

endmodule

// ===== test/bezier_point_eval_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bezier_point_eval_tb
// Self-checking bench for the Bernstein-form Bezier point evaluator.
// Loads degree and control points through the register port, streams t words
// with random gaps and output stalls, and checks every x/y pair against an
// exact wide-integer evaluation of the curve held in the bench.
// ----------------------------------------------------------------------------
module bezier_point_eval_tb;
  import bpe_pkg::*;

  localparam logic [16:0] T_ONE       = 17'h10000;
  localparam int          LATENCY     = 7;
  localparam int          DRAIN_LIMIT = 2000;
  localparam int          MAX_REPORTS = 10;
  localparam int          IDLE_PCT    = 30;
  localparam int          NUM_PHASES  = 12;
  localparam int          PHASE_WORDS = 75;
  localparam int          STEADY_PHASE = 6;
  // first index past the register map
  localparam logic [CFG_IDX_BITS-1:0] IDX_UNMAPPED = CFG_IDX_BITS'(REG_POINT_THREE + 1);

  typedef struct {
    logic [16:0] t;
    logic [15:0] x;
    logic [15:0] y;
  } curve_pt_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [16:0] t_param   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] x_coord;
  logic [15:0] y_coord;

  // bench copy of the register file
  logic [1:0]  curve_degree = 2'd3;
  logic [31:0] ctrl_pt [4]  = '{default: '0};

  curve_pt_t   pending_points [$];
  logic        steady_run    = 1'b0;
  int          mismatches    = 0;
  int          items_sent    = 0;
  int          results_seen  = 0;
  int          curves_loaded = 0;

  bezier_point_eval dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .t_param   (t_param),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .x_coord   (x_coord),
    .y_coord   (y_coord)
  );

  always #2 clk = ~clk;

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // exact Bernstein sum, then round to nearest with ties up
  function automatic logic [15:0] bernstein_axis(int unsigned n, logic [16:0] t,
                                                 logic [3:0][15:0] c);
    logic [95:0] acc;
    logic [95:0] term;
    logic [16:0] u;
    u   = T_ONE - t;
    acc = '0;
    for (int k = 0; k <= n; k++) begin
      term = (k == 0 || k == n) ? 96'd1 : 96'(n);
      for (int j = 0; j < n - k; j++) term = term * u;
      for (int j = 0; j < k; j++) term = term * t;
      term = term * c[k];
      acc  = acc + term;
    end
    if (n != 0) acc = (acc + (96'd1 << (16 * n - 1))) >> (16 * n);
    return acc[15:0];
  endfunction

  function automatic curve_pt_t predict_point(logic [16:0] t_in);
    curve_pt_t        pt;
    logic [16:0]      tc;
    logic [3:0][15:0] xs;
    logic [3:0][15:0] ys;
    tc = (t_in > T_ONE) ? T_ONE : t_in;
    for (int k = 0; k < 4; k++) begin
      xs[k] = ctrl_pt[k][31:16];
      ys[k] = ctrl_pt[k][15:0];
    end
    pt.t = t_in;
    pt.x = bernstein_axis(int'(curve_degree), tc, xs);
    pt.y = bernstein_axis(int'(curve_degree), tc, ys);
    return pt;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] rand_t();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 17'($urandom_range(131071));
    if (r < 16) begin
      case ($urandom_range(3))
        0:       return 17'd0;
        1:       return 17'd1;
        2:       return T_ONE - 17'd1;
        default: return T_ONE;
      endcase
    end
    return 17'($urandom_range(65536));
  endfunction

  // receiver: random stalls unless in the steady stretch
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else     out_stall <= !steady_run && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : check_results
    curve_pt_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        flag_error($sformatf("unexpected word x=%h y=%h", x_coord, y_coord));
      end else begin
        want = pending_points.pop_front();
        results_seen++;
        if (x_coord !== want.x)
          flag_error($sformatf("t=%h x expected %h got %h", want.t, want.x, x_coord));
        if (y_coord !== want.y)
          flag_error($sformatf("t=%h y expected %h got %h", want.t, want.y, y_coord));
      end
    end
  end

  // hold the register write for one edge, then release it
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_DEGREE:      curve_degree = data[1:0];
      REG_POINT_ZERO:  ctrl_pt[0]   = data;
      REG_POINT_ONE:   ctrl_pt[1]   = data;
      REG_POINT_TWO:   ctrl_pt[2]   = data;
      REG_POINT_THREE: ctrl_pt[3]   = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_curve(logic [1:0] deg, logic [31:0] p0, logic [31:0] p1,
                            logic [31:0] p2, logic [31:0] p3);
    logic [31:0] junk;
    junk = $urandom;
    // stray upper bits in the degree word must be dropped
    write_reg(REG_DEGREE, {junk[31:2], deg});
    write_reg(REG_POINT_ZERO, p0);
    write_reg(REG_POINT_ONE, p1);
    write_reg(REG_POINT_TWO, p2);
    write_reg(REG_POINT_THREE, p3);
    curves_loaded++;
  endtask

  task automatic send_t(logic [16:0] t);
    if (!steady_run) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    t_param  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_points.insert(pending_points.size(), predict_point(t));
    items_sent++;
  endtask

  task automatic drain();
    int waited;
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending_points.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_points.size() != 0) begin
      flag_error($sformatf("%0d words never arrived", pending_points.size()));
      pending_points.delete();
    end
  endtask

  task automatic test_reset_state();
    send_t(17'd0);
    send_t(T_ONE >> 1);
    send_t(T_ONE);
    drain();
  endtask

  task automatic test_extremes();
    logic [16:0] t_edges [7];
    t_edges = '{17'd0, 17'd1, T_ONE >> 1, T_ONE - 17'd1, T_ONE, T_ONE + 17'd1,
                17'h1FFFF};
    load_curve(2'd3, 32'h0000FFFF, 32'hFFFF0000, 32'hFFFFFFFF, 32'h00000000);
    foreach (t_edges[i]) send_t(t_edges[i]);
    drain();
    for (int d = 0; d < 3; d++) begin
      load_curve(2'(d), 32'hFFFF0000, 32'h0000FFFF, 32'h8001FFFF, 32'h12345678);
      send_t(17'd0);
      send_t(T_ONE >> 1);
      send_t(T_ONE);
      send_t(17'h1FFFF);
      drain();
    end
    // full-scale points: largest possible sums, must not wrap
    load_curve(2'd3, '1, '1, '1, '1);
    send_t(17'd21845);
    send_t(17'd43690);
    drain();
  endtask

  task automatic test_unmapped_index();
    load_curve(2'd2, 32'h10002000, 32'h30004000, 32'h50006000, 32'h70008000);
    for (int i = IDX_UNMAPPED; i < (1 << CFG_IDX_BITS); i++)
      write_reg(CFG_IDX_BITS'(i), 32'hFFFFFFFF);
    send_t(T_ONE >> 2);
    send_t(T_ONE);
    drain();
  endtask

  task automatic test_random_curves();
    logic [1:0] deg;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      deg = (ph < 4) ? 2'(ph) : 2'($urandom_range(3));
      if (ph == 4)
        load_curve(2'd3, '1, '1, '1, '1);
      else
        load_curve(deg, {rand_coord(), rand_coord()}, {rand_coord(), rand_coord()},
                   {rand_coord(), rand_coord()}, {rand_coord(), rand_coord()});
      steady_run = (ph == STEADY_PHASE);
      for (int i = 0; i < PHASE_WORDS; i++) send_t(rand_t());
      drain();
      steady_run = 1'b0;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_extremes();
    test_unmapped_index();
    test_random_curves();
    drain();
    // leave room for any stray word to show up
    repeat (2 * LATENCY) @(posedge clk);
    $display("Sent %0d t words across %0d curve settings (degrees 0-3, clamped t).",
             items_sent, curves_loaded);
    $display("Checked %0d points, %0d errors.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("** bezier_point_eval: PASSED **");
    end else begin
      $display("** bezier_point_eval: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d words outstanding.", pending_points.size());
    $display("** bezier_point_eval: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bpe_pkg.sv
rtl/bpe_axis.sv
rtl/bezier_point_eval.sv
test/bezier_point_eval_tb.sv
